>>> rtl/sliding_window_rank_filter_assert.svh
// Assertion macros used by the rank filter port checker.
`ifndef SLIDING_WINDOW_RANK_FILTER_ASSERT_SVH
`define SLIDING_WINDOW_RANK_FILTER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define SWRF_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rank filter check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define SWRF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rank filter check failed");

`endif

>>> rtl/swrf_pkg.sv
// Shared types and constants of the sliding window rank filter.
package swrf_pkg;

   localparam int RANK_BITS      = 3;
   localparam int SCALE_BITS     = 11;
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 11;
   localparam int RANGE_MARGIN   = 2;

   localparam logic [CSR_INDEX_BITS-1:0] RANK_SELECT_IDX    = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] ADC_FULL_SCALE_IDX = 4'd1;

   localparam logic [RANK_BITS-1:0]  RANK_RESET       = 3'd4;
   localparam logic [SCALE_BITS-1:0] FULL_SCALE_RESET = 11'd1024;

   // controller to datapath
   typedef struct packed {
      logic load;    // write the new word, clear lane counts
      logic count;   // compare one window entry against every lane
      logic pick;    // test one lane for the selected rank
      logic emit;    // move the picked value to the output register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic last;    // scan index is at the final entry
      logic hit;     // lane under the scan index holds the selected rank
   } sts_type;

endpackage

>>> rtl/sliding_window_rank_filter.sv
// Sliding window rank filter for raw ADC samples. Each accepted word writes
// its sample over the oldest of the last WINDOW samples (the window starts
// as zeros) and returns the window entry at ascending position rank_select,
// the median at the reset rank of 4; a rank beyond the window takes the
// largest entry. status is 1 when that value is below 2 or above
// adc_full_scale - 2. After acceptance, one counting pass compares each
// window entry against all entries in parallel lanes, then a scan over the
// lanes stops at the entry whose counts bracket the rank, and the picked
// value moves to the output register once a stalled previous result has
// left it. One item is in work at a time; a new word is taken as soon as
// the previous one has reached the output register. csr_ready is always
// high; write registers only while the block is idle.
module sliding_window_rank_filter #(
   parameter int WINDOW      = 8,
   parameter int SAMPLE_BITS = 10
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [SAMPLE_BITS-1:0]               req_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [SAMPLE_BITS-1:0]               rsp_filtered,
   output logic                                 rsp_status,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [swrf_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [swrf_pkg::CSR_DATA_BITS-1:0]   csr_data
);

   logic [swrf_pkg::RANK_BITS-1:0]  rank_select_ff;
   logic [swrf_pkg::SCALE_BITS-1:0] adc_full_scale_ff;
   swrf_pkg::cmd_type               cmd;
   swrf_pkg::sts_type               sts;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_select_ff    <= swrf_pkg::RANK_RESET;
         adc_full_scale_ff <= swrf_pkg::FULL_SCALE_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            swrf_pkg::RANK_SELECT_IDX: begin
               rank_select_ff <= csr_data[swrf_pkg::RANK_BITS-1:0];
            end
            swrf_pkg::ADC_FULL_SCALE_IDX: begin
               adc_full_scale_ff <= csr_data[swrf_pkg::SCALE_BITS-1:0];
            end
            default: begin
               // drop writes to unmapped registers
            end
         endcase
      end
   end

   swrf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   swrf_datapath #(
      .WINDOW      (WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .sample         (req_sample),
      .rank_select    (rank_select_ff),
      .adc_full_scale (adc_full_scale_ff),
      .filtered       (rsp_filtered),
      .status         (rsp_status)
   );

endmodule

>>> rtl/swrf_ctrl.sv
// Controller state machine of the sliding window rank filter.
module swrf_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  swrf_pkg::sts_type sts,
   output swrf_pkg::cmd_type cmd
);

   typedef enum logic [1:0] {
      IDLE,
      COUNT,
      PICK,
      HOLD
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      accept;
   logic      out_free;

   assign accept    = req_valid && (state_ff == IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != IDLE);
   assign rsp_valid = rsp_valid_ff;

   assign cmd.load  = accept;
   assign cmd.count = (state_ff == COUNT);
   assign cmd.pick  = (state_ff == PICK);
   assign cmd.emit  = (state_ff == HOLD) && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if ((state_ff == HOLD) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            IDLE: begin
               if (accept) begin
                  state_ff <= COUNT;
               end
            end
            COUNT: begin
               if (sts.last) begin
                  state_ff <= PICK;
               end
            end
            PICK: begin
               if (sts.hit) begin
                  state_ff <= HOLD;
               end
            end
            HOLD: begin
               // wait until the output register can take the word
               if (out_free) begin
                  state_ff <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

endmodule

>>> rtl/swrf_datapath.sv
// Window storage, rank counting lanes and output register of the rank filter.
module swrf_datapath #(
   parameter int WINDOW      = 8,
   parameter int SAMPLE_BITS = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   input  swrf_pkg::cmd_type                 cmd,
   output swrf_pkg::sts_type                 sts,
   input  logic [SAMPLE_BITS-1:0]            sample,
   input  logic [swrf_pkg::RANK_BITS-1:0]    rank_select,
   input  logic [swrf_pkg::SCALE_BITS-1:0]   adc_full_scale,
   output logic [SAMPLE_BITS-1:0]            filtered,
   output logic                              status
);

   localparam int IW   = $clog2(WINDOW);
   localparam int CW   = $clog2(WINDOW + 1);
   localparam int CMPW = ((SAMPLE_BITS > swrf_pkg::SCALE_BITS) ?
                          SAMPLE_BITS : swrf_pkg::SCALE_BITS) + 1;
   localparam logic [IW-1:0] LAST_IDX = IW'(WINDOW - 1);
   localparam logic [CW-1:0] TOP_RANK = CW'(WINDOW - 1);

   logic [SAMPLE_BITS-1:0] window_ff [WINDOW];
   logic [CW-1:0]          less_ff   [WINDOW];
   logic [CW-1:0]          le_ff     [WINDOW];
   logic [CW-1:0]          less_in   [WINDOW];
   logic [CW-1:0]          le_in     [WINDOW];
   logic [IW-1:0]          slot_ff;
   logic [IW-1:0]          idx_ff;
   logic [SAMPLE_BITS-1:0] pick_ff;
   logic [SAMPLE_BITS-1:0] filtered_ff;
   logic                   status_ff;
   logic [SAMPLE_BITS-1:0] elem;
   logic [CW-1:0]          rank_ext;
   logic [CW-1:0]          rank;
   logic                   bad;

   assign elem     = window_ff[idx_ff];
   assign rank_ext = CW'(rank_select);
   // a rank past the window saturates to the largest entry
   assign rank     = (rank_ext > TOP_RANK) ? TOP_RANK : rank_ext;

   always_comb begin
      for (int j = 0; j < WINDOW; j++) begin
         less_in[j] = less_ff[j] + CW'(elem < window_ff[j]);
         le_in[j]   = le_ff[j] + CW'(elem <= window_ff[j]);
      end
   end

   assign sts.last = (idx_ff == LAST_IDX);
   assign sts.hit  = (less_ff[idx_ff] <= rank) && (le_ff[idx_ff] > rank);

   // low or high end of the ADC range: v < 2 or v + 2 > full scale
   assign bad = (pick_ff < SAMPLE_BITS'(swrf_pkg::RANGE_MARGIN)) ||
                ((CMPW'(pick_ff) + CMPW'(swrf_pkg::RANGE_MARGIN)) > CMPW'(adc_full_scale));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < WINDOW; j++) begin
            window_ff[j] <= '0;
         end
         slot_ff <= '0;
         idx_ff  <= '0;
      end else begin
         if (cmd.load) begin
            window_ff[slot_ff] <= sample;
            slot_ff <= (slot_ff == LAST_IDX) ? '0 : slot_ff + 1'b1;
            idx_ff  <= '0;
         end else if (cmd.count) begin
            idx_ff <= (idx_ff == LAST_IDX) ? '0 : idx_ff + 1'b1;
         end else if (cmd.pick && !sts.hit) begin
            idx_ff <= (idx_ff == LAST_IDX) ? '0 : idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < WINDOW; j++) begin
         if (cmd.load) begin
            less_ff[j] <= '0;
            le_ff[j]   <= '0;
         end else if (cmd.count) begin
            less_ff[j] <= less_in[j];
            le_ff[j]   <= le_in[j];
         end
      end
      if (cmd.pick && sts.hit) begin
         pick_ff <= window_ff[idx_ff];
      end
      if (cmd.emit) begin
         filtered_ff <= pick_ff;
         status_ff   <= bad;
      end
   end

   assign filtered = filtered_ff;
   assign status   = status_ff;

endmodule

>>> rtl/swrf_checker.sv
// Port checker for the sliding window rank filter and its bind.
`include "sliding_window_rank_filter_assert.svh"

module swrf_checker #(
   parameter int SAMPLE_BITS = 10
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [SAMPLE_BITS-1:0] rsp_filtered,
   input logic                   rsp_status
);

   // hold a stalled result word
   `SWRF_ASSERT_NEXT(rsp_hold_valid, rsp_valid && rsp_stall, rsp_valid)
   `SWRF_ASSERT_NEXT(rsp_hold_payload, rsp_valid && rsp_stall,
                     $stable(rsp_filtered) && $stable(rsp_status))
   // one item at a time: busy right after taking a word
   `SWRF_ASSERT_NEXT(busy_after_accept, req_valid && !req_stall, req_stall)
   // a value near zero always flags the sensor
   `SWRF_ASSERT_IMPLY(low_value_flagged, rsp_valid && (rsp_filtered < 2), rsp_status)

endmodule

bind sliding_window_rank_filter swrf_checker #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_swrf_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_filtered (rsp_filtered),
   .rsp_status   (rsp_status)
);
